@@ hdl/bsrr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsrr_pkg: shared types and constants of the box shape row rasterizer
// Holds the shape codes, bitmap defaults, the controller state type and the
// command and status groups that link the controller to the datapath.
// ----------------------------------------------------------------------------
package bsrr_pkg;

    // Bitmap defaults, range 1 to 64 each
    localparam int BITMAP_WIDTH  = 64;
    localparam int BITMAP_HEIGHT = 64;

    // Mask lanes, one per pixel column of the write mask
    localparam int LANES = 64;

    // Shape codes
    localparam logic [1:0] OP_FILL    = 2'd0;
    localparam logic [1:0] OP_OUTLINE = 2'd1;
    localparam logic [1:0] OP_CIRCLE  = 2'd2;

    // Configuration reset value of the row pitch
    localparam logic [6:0] PITCH_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ROWS,
        ST_DRAIN
    } t_bsrr_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming command
        logic sweep;   // square one column offset of the circle
        logic issue;   // send the current row into the pipeline
    } t_bsrr_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cmd_ok;      // incoming command is drawable
        logic circle;      // incoming or held command is a circle
        logic sweep_last;  // column sweep is at its last column
        logic row_last;    // current row is the top row of the box
        logic a_valid;     // row stage holds a row
        logic adv;         // pipeline advances this cycle
    } t_bsrr_status;

endpackage

@@ hdl/bsrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsrr_ctrl: command sequencer
// Accepts a command, runs the circle column sweep when needed, issues one
// row per pipeline advance and waits for the last row to leave the row stage.
// ----------------------------------------------------------------------------
module bsrr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  bsrr_pkg::t_bsrr_status i_status,
    output bsrr_pkg::t_bsrr_cmd    o_cmd
);

    bsrr_pkg::t_bsrr_state r_state;
    bsrr_pkg::t_bsrr_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsrr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.sweep = 1'b0;
        o_cmd.issue = 1'b0;
        o_stall     = 1'b1;
        unique case (r_state)
            bsrr_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid && i_status.cmd_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.circle ? bsrr_pkg::ST_SWEEP : bsrr_pkg::ST_ROWS;
                end
            end
            bsrr_pkg::ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = bsrr_pkg::ST_ROWS;
                end
            end
            bsrr_pkg::ST_ROWS: begin
                o_cmd.issue = i_status.adv;
                if (i_status.adv && i_status.row_last) begin
                    n_state = bsrr_pkg::ST_DRAIN;
                end
            end
            bsrr_pkg::ST_DRAIN: begin
                // last row leaves the row stage on this advance
                if (i_status.adv) begin
                    n_state = bsrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsrr_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsrr_pkg::ST_IDLE) |-> !i_status.a_valid)
        else $error("row stage busy while idle");

    a_sweep_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsrr_pkg::ST_SWEEP) |-> i_status.circle)
        else $error("column sweep for a non-circle command");
`endif

endmodule

@@ hdl/bsrr_dp.sv @@
// ----------------------------------------------------------------------------
// bsrr_dp: rasterizer datapath
// Clamps and holds the command, squares column offsets for the circle, and
// runs a two-stage row pipeline (row threshold, then lane mask) into the
// output register.
// ----------------------------------------------------------------------------
module bsrr_dp #(
    parameter int P_BITMAP_WIDTH  = bsrr_pkg::BITMAP_WIDTH,
    parameter int P_BITMAP_HEIGHT = bsrr_pkg::BITMAP_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_opcode,
    input  logic [6:0]             i_x_min,
    input  logic [6:0]             i_y_min,
    input  logic [6:0]             i_x_max,
    input  logic [6:0]             i_y_max,
    input  logic [31:0]            i_color,
    input  logic                   i_cfg_valid,
    input  logic [6:0]             i_cfg_data,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [5:0]             o_row,
    output logic [11:0]            o_row_address,
    output logic [63:0]            o_write_mask,
    output logic [31:0]            o_pixel_color,
    output logic                   o_last_row,
    input  bsrr_pkg::t_bsrr_cmd     i_cmd,
    output bsrr_pkg::t_bsrr_status  o_status
);

    localparam logic [6:0] XLIM = 7'(P_BITMAP_WIDTH);
    localparam logic [6:0] YLIM = 7'(P_BITMAP_HEIGHT);

    // Clamped incoming command
    logic [6:0]  xmin_c, xmax_c, ymin_c, ymax_c;
    logic [6:0]  w_c, h_c, d_c;
    logic [13:0] d_sq;
    logic [7:0]  cx2_c, cy2_c;
    logic [bsrr_pkg::LANES-1:0] box_c, side_c;

    // Held command
    logic [1:0]  r_op;
    logic [6:0]  r_xmin, r_xmax, r_ymin, r_ymax;
    logic [31:0] r_color;
    logic [7:0]  r_cx2, r_cy2;
    logic [12:0] r_d2;
    logic [bsrr_pkg::LANES-1:0] r_box, r_side;
    logic [6:0]  r_pitch;

    // Column sweep
    logic [6:0]  r_sx;
    logic [13:0] r_dx2 [bsrr_pkg::LANES];
    logic [8:0]  dx;
    logic [6:0]  dx_abs;
    logic [13:0] dx_sq;

    // Row stage
    logic [6:0]  r_y;
    logic [8:0]  dy;
    logic [6:0]  dy_abs;
    logic [13:0] dy_sq;
    logic [14:0] thr;
    logic        row_last;
    logic        r_a_valid;
    logic [5:0]  r_a_y;
    logic [14:0] r_a_thr;
    logic        r_a_last;
    logic        r_a_edge;

    // Mask stage and output register
    logic [bsrr_pkg::LANES-1:0] circ;
    logic [bsrr_pkg::LANES-1:0] mask;
    logic [12:0] addr_full;
    logic        adv;
    logic        r_o_valid;
    logic [5:0]  r_o_row;
    logic [11:0] r_o_addr;
    logic [63:0] r_o_mask;
    logic [31:0] r_o_color;
    logic        r_o_last;

    // ---------------- incoming command ----------------
    always_comb begin
        xmin_c = (i_x_min > XLIM) ? XLIM : i_x_min;
        xmax_c = (i_x_max > XLIM) ? XLIM : i_x_max;
        ymin_c = (i_y_min > YLIM) ? YLIM : i_y_min;
        ymax_c = (i_y_max > YLIM) ? YLIM : i_y_max;
        w_c    = xmax_c - xmin_c;
        h_c    = ymax_c - ymin_c;
        d_c    = (w_c < h_c) ? w_c : h_c;
        d_sq   = d_c * d_c;
        cx2_c  = {1'b0, xmin_c} + {1'b0, xmax_c};
        cy2_c  = {1'b0, ymin_c} + {1'b0, ymax_c};
        for (int i = 0; i < bsrr_pkg::LANES; i++) begin
            box_c[i]  = (7'(i) >= xmin_c) && (7'(i) < xmax_c);
            side_c[i] = (7'(i) == xmin_c) || (7'(i) == xmax_c - 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_xmin  <= xmin_c;
            r_xmax  <= xmax_c;
            r_ymin  <= ymin_c;
            r_ymax  <= ymax_c;
            r_color <= i_color;
            r_cx2   <= cx2_c;
            r_cy2   <= cy2_c;
            r_d2    <= d_sq[12:0];
            r_box   <= box_c;
            r_side  <= side_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= bsrr_pkg::PITCH_RESET;
        end else if (i_cfg_valid) begin
            r_pitch <= i_cfg_data;
        end
    end

    // ---------------- column sweep ----------------
    always_comb begin
        dx     = {1'b0, r_sx, 1'b1} - {1'b0, r_cx2};
        dx_abs = dx[8] ? 7'(-dx) : dx[6:0];
        dx_sq  = dx_abs * dx_abs;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= xmin_c;
        end else if (i_cmd.sweep) begin
            r_dx2[r_sx[5:0]] <= dx_sq;
            r_sx             <= r_sx + 7'd1;
        end
    end

    // ---------------- row stage ----------------
    always_comb begin
        dy       = {1'b0, r_y, 1'b1} - {1'b0, r_cy2};
        dy_abs   = dy[8] ? 7'(-dy) : dy[6:0];
        dy_sq    = dy_abs * dy_abs;
        thr      = {2'b00, r_d2} - {1'b0, dy_sq};
        row_last = (r_y == r_ymax - 7'd1);
        adv      = !r_o_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y <= ymin_c;
        end else if (i_cmd.issue) begin
            r_y <= r_y + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_a_y    <= r_y[5:0];
            r_a_thr  <= thr;
            r_a_last <= row_last;
            r_a_edge <= (r_y == r_ymin) || row_last;
        end
    end

    // ---------------- mask stage ----------------
    always_comb begin
        for (int i = 0; i < bsrr_pkg::LANES; i++) begin
            circ[i] = !r_a_thr[14] && (r_dx2[i] <= r_a_thr[13:0]);
        end
        case (r_op)
            bsrr_pkg::OP_FILL:    mask = r_box;
            bsrr_pkg::OP_OUTLINE: mask = r_a_edge ? r_box : r_side;
            bsrr_pkg::OP_CIRCLE:  mask = r_box & circ;
            default:              mask = '0;
        endcase
        addr_full = r_a_y * r_pitch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_a_valid) begin
            r_o_row   <= r_a_y;
            r_o_addr  <= addr_full[11:0];
            r_o_mask  <= mask;
            r_o_color <= r_color;
            r_o_last  <= r_a_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_row         = r_o_row;
    assign o_row_address = r_o_addr;
    assign o_write_mask  = r_o_mask;
    assign o_pixel_color = r_o_color;
    assign o_last_row    = r_o_last;

    assign o_status.cmd_ok     = ((i_opcode == bsrr_pkg::OP_FILL)
                                  || (i_opcode == bsrr_pkg::OP_OUTLINE)
                                  || (i_opcode == bsrr_pkg::OP_CIRCLE))
                                 && (xmin_c < xmax_c) && (ymin_c < ymax_c);
    assign o_status.circle     = i_cmd.load ? (i_opcode == bsrr_pkg::OP_CIRCLE)
                                            : (r_op == bsrr_pkg::OP_CIRCLE);
    assign o_status.sweep_last = (r_sx == r_xmax - 7'd1);
    assign o_status.row_last   = row_last;
    assign o_status.a_valid    = r_a_valid;
    assign o_status.adv        = adv;

`ifndef SYNTHESIS
    a_sweep_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |-> ((r_sx >= r_xmin) && (r_sx < r_xmax)))
        else $error("column sweep outside the box");

    a_row_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (({1'b0, r_a_y} >= r_ymin) && ({1'b0, r_a_y} < r_ymax)))
        else $error("row stage holds a row outside the box");
`endif

endmodule

@@ hdl/box_shape_row_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// box_shape_row_rasterizer_unit: draw command to per-row write masks
// Rasterizes a filled rectangle, a rectangle outline or a filled circle in a
// half-open pixel box into one beat per row: row, base address, 64-bit write
// mask and color, with the top row of the command marked as last.
//
//   channel   direction  handshake                 payload
//   command   in         i_valid / o_stall         i_opcode, i_x_min, i_y_min,
//                                                  i_x_max, i_y_max, i_color
//   row       out        o_valid / i_stall         o_row, o_row_address,
//                                                  o_write_mask, o_pixel_color,
//                                                  o_last_row
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_data (row pitch)
//
// A command is taken in one beat; a circle then squares one box column offset
//   per cycle, then rows issue one per cycle while the output is not stalled;
//   the next command is taken once the last row has left the row stage.
// A row beat is registered by the threshold stage and then by the mask stage;
//   a beat that waits holds in the output register.
// A stalled output freezes the whole row pipeline; the column sweep does not
//   depend on the output side.
// Empty boxes and the unused shape code are taken and produce no beat.
// Reset is synchronous and clears the sequencer, the pipeline valids and the
//   row pitch (to 64); no stored data needs clearing.
// ----------------------------------------------------------------------------
module box_shape_row_rasterizer_unit #(
    parameter int P_BITMAP_WIDTH  = bsrr_pkg::BITMAP_WIDTH,
    parameter int P_BITMAP_HEIGHT = bsrr_pkg::BITMAP_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [6:0]  i_x_min,
    input  logic [6:0]  i_y_min,
    input  logic [6:0]  i_x_max,
    input  logic [6:0]  i_y_max,
    input  logic [31:0] i_color,

    // row channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_row,
    output logic [11:0] o_row_address,
    output logic [63:0] o_write_mask,
    output logic [31:0] o_pixel_color,
    output logic        o_last_row,

    // row pitch register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    bsrr_pkg::t_bsrr_cmd    cmd;
    bsrr_pkg::t_bsrr_status status;

    // User must land pitch writes only between commands (unchecked); ready=1
    assign o_cfg_ready = 1'b1;

    bsrr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bsrr_dp #(
        .P_BITMAP_WIDTH  (P_BITMAP_WIDTH),
        .P_BITMAP_HEIGHT (P_BITMAP_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_opcode      (i_opcode),
        .i_x_min       (i_x_min),
        .i_y_min       (i_y_min),
        .i_x_max       (i_x_max),
        .i_y_max       (i_y_max),
        .i_color       (i_color),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_row         (o_row),
        .o_row_address (o_row_address),
        .o_write_mask  (o_write_mask),
        .o_pixel_color (o_pixel_color),
        .o_last_row    (o_last_row),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

@@ sim/box_shape_row_rasterizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// box_shape_row_rasterizer_unit_tb: self-checking bench of the row rasterizer
// Sends draw commands (fill, outline, circle, empty, clamped and unused
// shapes) under random gaps and output stalls, predicts every row beat with
// its own integer rasterizer and compares each row beat field by field.
// ----------------------------------------------------------------------------
module box_shape_row_rasterizer_unit_tb;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         LONG_HOLD      = 200;
    localparam int         RANDOM_DRAWS   = 60;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  x_min;
        logic [6:0]  y_min;
        logic [6:0]  x_max;
        logic [6:0]  y_max;
        logic [31:0] color;
    } t_draw_cmd;

    typedef struct packed {
        logic [5:0]  row;
        logic [11:0] row_address;
        logic [63:0] write_mask;
        logic [31:0] pixel_color;
        logic        last_row;
    } t_row_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [6:0]  i_x_min = '0;
    logic [6:0]  i_y_min = '0;
    logic [6:0]  i_x_max = '0;
    logic [6:0]  i_y_max = '0;
    logic [31:0] i_color = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_row;
    logic [11:0] o_row_address;
    logic [63:0] o_write_mask;
    logic [31:0] o_pixel_color;
    logic        o_last_row;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;

    t_row_beat   row_beats_due[$];
    logic [6:0]  pitch_setting = bsrr_pkg::PITCH_RESET;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          row_hold_req = 0;
    bit          beat_taken = 1'b0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    box_shape_row_rasterizer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_x_min       (i_x_min),
        .i_y_min       (i_y_min),
        .i_x_max       (i_x_max),
        .i_y_max       (i_y_max),
        .i_color       (i_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_row         (o_row),
        .o_row_address (o_row_address),
        .o_write_mask  (o_write_mask),
        .o_pixel_color (o_pixel_color),
        .o_last_row    (o_last_row),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int clamp_coord(logic [6:0] v, int limit);
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    // Rasterize one command into the row beats it owes; return the row count.
    function automatic int rasterize_command(t_draw_cmd c);
        int        xl, yl, xh, yh, d, dx, dy;
        bit        on;
        t_row_beat beat;
        xl = clamp_coord(c.x_min, bsrr_pkg::BITMAP_WIDTH);
        yl = clamp_coord(c.y_min, bsrr_pkg::BITMAP_HEIGHT);
        xh = clamp_coord(c.x_max, bsrr_pkg::BITMAP_WIDTH);
        yh = clamp_coord(c.y_max, bsrr_pkg::BITMAP_HEIGHT);
        if (!(c.opcode == bsrr_pkg::OP_FILL || c.opcode == bsrr_pkg::OP_OUTLINE
              || c.opcode == bsrr_pkg::OP_CIRCLE))
            return 0;
        if (xl >= xh || yl >= yh)
            return 0;
        d = ((xh - xl) < (yh - yl)) ? (xh - xl) : (yh - yl);
        for (int y = yl; y < yh; y++) begin
            beat.row         = y[5:0];
            beat.row_address = 12'(y * int'(pitch_setting));
            beat.write_mask  = '0;
            beat.pixel_color = c.color;
            beat.last_row    = (y + 1 == yh);
            for (int x = xl; x < xh; x++) begin
                case (c.opcode)
                    bsrr_pkg::OP_FILL: on = 1'b1;
                    // keep only the one-pixel border ring
                    bsrr_pkg::OP_OUTLINE:
                        on = !(x > xl && y > yl && x < xh - 1 && y < yh - 1);
                    default: begin
                        // pixel centre test on doubled coordinates
                        dx = 2 * x + 1 - (xl + xh);
                        dy = 2 * y + 1 - (yl + yh);
                        on = (dx * dx + dy * dy) <= d * d;
                    end
                endcase
                if (on)
                    beat.write_mask[x] = 1'b1;
            end
            row_beats_due.push_back(beat);
        end
        return yh - yl;
    endfunction

    function automatic t_draw_cmd mk_cmd(logic [1:0] op, logic [6:0] xl, logic [6:0] yl,
                                         logic [6:0] xh, logic [6:0] yh, logic [31:0] color);
        t_draw_cmd c;
        c = '{op, xl, yl, xh, yh, color};
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Send one command beat, after a random gap when idling is on; return the rows it owes.
    task automatic send_command(input t_draw_cmd c, output int rows);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode = c.opcode;
        i_x_min  = c.x_min;
        i_y_min  = c.y_min;
        i_x_max  = c.x_max;
        i_y_max  = c.y_max;
        i_color  = c.color;
        i_valid  = 1'b1;
        do @(posedge i_clk); while (o_stall);
        rows = rasterize_command(c);
    endtask

    task automatic send(input t_draw_cmd c);
        int rows;
        send_command(c, rows);
    endtask

    // Drop valid and hold until every owed row beat has come back.
    task automatic wait_rows_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (row_beats_due.size() != 0) @(negedge i_clk);
    endtask

    // Write the row pitch only once the block has gone quiet.
    task automatic write_row_pitch(input logic [6:0] pitch);
        wait_rows_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_data  = pitch;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        pitch_setting = pitch;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly well-formed small boxes, some large ones, some raw noise.
    function automatic t_draw_cmd random_command();
        t_draw_cmd c;
        int        xl, yl;
        c.color  = $urandom;
        c.opcode = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0: begin
                c.opcode = 2'($urandom_range(0, 3));
                c.x_min  = 7'($urandom);
                c.y_min  = 7'($urandom);
                c.x_max  = 7'($urandom);
                c.y_max  = 7'($urandom);
            end
            1: begin
                c.x_min = 7'($urandom_range(0, 8));
                c.y_min = 7'($urandom_range(0, 8));
                c.x_max = 7'($urandom_range(56, 127));
                c.y_max = 7'($urandom_range(56, 127));
            end
            default: begin
                xl      = $urandom_range(0, 63);
                yl      = $urandom_range(0, 63);
                c.x_min = 7'(xl);
                c.y_min = 7'(yl);
                c.x_max = 7'(xl + $urandom_range(1, 9));
                c.y_max = 7'(yl + $urandom_range(1, 9));
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Row side: random stall after each beat, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : row_receiver
        int gap;
        forever begin
            @(negedge i_clk);
            if (row_hold_req > 0) begin
                i_stall = 1'b1;
                repeat (row_hold_req) @(negedge i_clk);
                row_hold_req = 0;
                i_stall = 1'b0;
            end else if (beat_taken) begin
                beat_taken = 1'b0;
                gap = rx_idle_on ? $urandom_range(0, 8) : 0;
                if (gap > 0) begin
                    i_stall = 1'b1;
                    repeat (gap) @(negedge i_clk);
                    i_stall = 1'b0;
                end
            end
        end
    end

    // Compare each accepted row beat with the oldest owed beat.
    always @(posedge i_clk) begin
        t_row_beat due;
        if (i_rst_n && o_valid && !i_stall) begin
            beat_taken = 1'b1;
            if (row_beats_due.size() == 0) begin
                $error("unexpected row beat: row %0d", o_row);
                fail_count++;
            end else begin
                due = row_beats_due.pop_front();
                if (o_row !== due.row) begin
                    $error("row: expected %0d, got %0d", due.row, o_row);
                    fail_count++;
                end
                if (o_row_address !== due.row_address) begin
                    $error("row_address: expected %0d, got %0d",
                           due.row_address, o_row_address);
                    fail_count++;
                end
                if (o_write_mask !== due.write_mask) begin
                    $error("write_mask: expected %h, got %h", due.write_mask, o_write_mask);
                    fail_count++;
                end
                if (o_pixel_color !== due.pixel_color) begin
                    $error("pixel_color: expected %h, got %h",
                           due.pixel_color, o_pixel_color);
                    fail_count++;
                end
                if (o_last_row !== due.last_row) begin
                    $error("last_row: expected %0d, got %0d", due.last_row, o_last_row);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles with no beat on any channel; end the run on a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_fill_and_outline();
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd0, 7'd0, 7'd64, 7'd64, 32'hFFFF_FFFF));
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd63, 7'd63, 7'd64, 7'd64, 32'h0000_0000));
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd0, 7'd10, 7'd1, 7'd12, 32'hA5A5_A5A5));
        send(mk_cmd(bsrr_pkg::OP_OUTLINE, 7'd0, 7'd0, 7'd64, 7'd64, 32'h5A5A_5A5A));
        send(mk_cmd(bsrr_pkg::OP_OUTLINE, 7'd5, 7'd5, 7'd6, 7'd6, 32'h1234_5678));
        send(mk_cmd(bsrr_pkg::OP_OUTLINE, 7'd2, 7'd3, 7'd4, 7'd5, 32'h8765_4321));
        send(mk_cmd(bsrr_pkg::OP_OUTLINE, 7'd10, 7'd20, 7'd13, 7'd23, 32'hDEAD_BEEF));
        send(mk_cmd(bsrr_pkg::OP_OUTLINE, 7'd0, 7'd0, 7'd64, 7'd3, 32'h0F0F_0F0F));
    endtask

    task automatic test_circle();
        send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd0, 7'd0, 7'd64, 7'd64, 32'hCAFE_F00D));
        send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd3, 7'd3, 7'd8, 7'd8, 32'h0000_00FF));
        send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd0, 7'd0, 7'd10, 7'd4, 32'hFF00_0000));
        send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd40, 7'd2, 7'd44, 7'd30, 32'h00FF_FF00));
        send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd7, 7'd7, 7'd8, 7'd8, 32'h7777_7777));
        send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd60, 7'd60, 7'd127, 7'd100, 32'h1111_2222));
    endtask

    // Empty boxes, the unused shape code and clamped coordinates.
    task automatic test_degenerate_boxes();
        send(mk_cmd(OP_UNUSED, 7'd0, 7'd0, 7'd64, 7'd64, 32'hFFFF_FFFF));
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd5, 7'd0, 7'd5, 7'd10, 32'h0000_0001));
        send(mk_cmd(bsrr_pkg::OP_OUTLINE, 7'd0, 7'd10, 7'd8, 7'd9, 32'h0000_0002));
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd127, 7'd0, 7'd127, 7'd4, 32'h0000_0003));
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd60, 7'd120, 7'd127, 7'd127, 32'h0000_0004));
        send(mk_cmd(bsrr_pkg::OP_FILL, 7'd60, 7'd62, 7'd127, 7'd127, 32'h8000_0000));
    endtask

    task automatic test_row_pitch();
        logic [6:0] pitches[4];
        pitches = '{7'd1, 7'd127, 7'd0, 7'd37};
        foreach (pitches[i]) begin
            write_row_pitch(pitches[i]);
            send(mk_cmd(bsrr_pkg::OP_FILL, 7'd0, 7'd56, 7'd64, 7'd64, $urandom));
            send(mk_cmd(bsrr_pkg::OP_CIRCLE, 7'd20, 7'd0, 7'd26, 7'd6, $urandom));
        end
    endtask

    // Hold the row side off while commands keep coming, then let the
    // command side pause until every owed beat is back; two random batches follow.
    task automatic test_backpressure();
        write_row_pitch(bsrr_pkg::PITCH_RESET);
        tx_idle_on   = 1'b0;
        row_hold_req = LONG_HOLD;
        repeat (5) send(mk_cmd(bsrr_pkg::OP_FILL, 7'd0, 7'($urandom_range(0, 50)), 7'd64,
                               7'd64, $urandom));
        wait_rows_drained();
        tx_idle_on = 1'b1;
        repeat (3) send(random_command());
        wait_rows_drained();
        repeat (3) send(random_command());
    endtask

    // Random commands in four phases, each at its own row pitch; some
    // stretches run without any idling on either side.
    task automatic test_random_commands();
        int drawn, rows, phase;
        drawn = 0;
        phase = 0;
        while (drawn < RANDOM_DRAWS) begin
            if (drawn >= phase * (RANDOM_DRAWS / 4)) begin
                write_row_pitch(phase == 0 ? 7'd127 : 7'($urandom_range(0, 127)));
                phase++;
            end
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            send_command(random_command(), rows);
            if (rows > 0)
                drawn++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fill_and_outline();
        test_circle();
        test_degenerate_boxes();
        test_row_pitch();
        test_backpressure();
        test_random_commands();

        wait_rows_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
